FILE: hdl/sps_pkg.sv
`default_nettype none

package sps_pkg;

    localparam int CHANNELS = 8;
    localparam int CH_W     = $clog2(CHANNELS);

    localparam logic [15:0] WIDTH_RESET = 16'd1500;
    localparam logic [15:0] MIN_RESET   = 16'd500;
    localparam logic [15:0] MAX_RESET   = 16'd2500;

    typedef enum logic {
        ACT_TICK  = 1'b0,
        ACT_STORE = 1'b1
    } t_action;

    typedef enum logic {
        CFG_MIN = 1'b0,
        CFG_MAX = 1'b1
    } t_cfg_reg;

    // Channel after ch, wrapping to 0 past the last channel.
    function automatic logic [CH_W-1:0] sps_next_ch(input logic [CH_W-1:0] ch);
        logic [CH_W-1:0] res;
        if (32'(ch) >= CHANNELS - 1) begin
            res = '0;
        end else begin
            res = ch + CH_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/servo_pulse_sequencer.sv
`default_nettype none

// Channel   Ports                               Payload (low bit first)
// --------  ----------------------------------  -------------------------------------------
// in        i_s_tvalid/o_s_tready/i_s_tdata     tdata: channel_sel[2:0], raw_width[18:3]
//           i_s_tuser                           tuser: action (0 tick, 1 store)
// out       o_m_tvalid/i_m_tready/o_m_tdata     tdata: line_pattern[7:0], active_channel[10:8]
//           o_m_tuser                           tuser: slot_start
// cfg       i_cfg_valid/o_cfg_ready             index 0 min width, 1 max width
//           i_cfg_index/i_cfg_data
//
// One request per cycle sustained while the output does not stall. The slot width is read from
// memory at the accept edge (address prefetched from the channel counter); the request then
// passes the execute stage and its result is offered from the output register.
// A write in execute to the entry being read in the same cycle is forwarded.
// Reset is synchronous; width entries read as 1500 until written (per-entry valid bits).
// Output stall holds the execute stage; input ready drops only when both are full.

module servo_pulse_sequencer
    import sps_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // channel_sel[2:0], raw_width[18:3], zero pad
    input  wire logic        i_s_tuser,   // action
    // result stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // line_pattern[7:0], active_channel[10:8], zero pad
    output logic             o_m_tuser,   // slot_start
    // configuration
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    // width store: synchronous RAM plus valid bits standing in for the reset value
    logic [15:0]         r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;

    logic [15:0]     r_min;
    logic [15:0]     r_max;
    logic [CH_W-1:0] r_cur;
    logic [15:0]     r_rem;
    logic [7:0]      r_drive;

    // execute stage
    logic        r_s1_vld;
    t_action     r_s1_act;
    logic [2:0]  r_s1_sel;
    logic [15:0] r_s1_pulse;
    logic [15:0] r_rd_data;
    logic        r_rd_vld;
    logic        r_fwd;
    logic [15:0] r_fwd_data;

    // output register
    logic        r_out_vld;
    logic [15:0] r_out_data;
    logic        r_out_user;

    logic            s_accept;
    logic            s1_fire;
    logic            s1_start;
    logic            s1_store;
    logic [CH_W-1:0] s1_next;
    logic [15:0]     w_raw;
    logic [15:0]     w_max;
    logic [15:0]     w_clmp;
    logic            mem_we;
    logic [CH_W-1:0] mem_waddr;
    logic [15:0]     mem_wdata;
    logic [CH_W-1:0] mem_raddr;
    logic [CH_W-1:0] n_cur;
    logic [15:0]     n_rem;
    logic [7:0]      n_drive;

    assign o_cfg_ready = 1'b1;

    assign s1_fire    = r_s1_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_s1_vld || s1_fire;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign s1_next  = sps_next_ch(r_cur);
    assign s1_start = (r_s1_act == ACT_TICK) && (r_rem == 16'd0);
    assign s1_store = (r_s1_act == ACT_STORE) && (32'(r_s1_sel) < CHANNELS);

    // stored width of the slot's channel, newest value first
    always_comb begin
        if (r_fwd) begin
            w_raw = r_fwd_data;
        end else if (r_rd_vld) begin
            w_raw = r_rd_data;
        end else begin
            w_raw = WIDTH_RESET;
        end
        w_max  = (w_raw > r_max) ? r_max : w_raw;
        w_clmp = (w_max < r_min) ? r_min : w_max;   // min clamp last: min wins
    end

    always_comb begin
        mem_we    = s1_fire && (s1_start || s1_store);
        mem_waddr = s1_start ? s1_next : CH_W'(r_s1_sel);
        mem_wdata = s1_start ? w_clmp : r_s1_pulse;

        n_cur   = r_cur;
        n_rem   = r_rem;
        n_drive = r_drive;
        if (s1_fire && r_s1_act == ACT_TICK) begin
            if (s1_start) begin
                n_cur   = s1_next;
                n_rem   = (w_clmp == 16'd0) ? 16'd0 : w_clmp - 16'd1;
                n_drive = 8'd1 << s1_next;
            end else begin
                n_rem = r_rem - 16'd1;
            end
        end
        // prefetch the width of the channel the following slot would use
        mem_raddr = sps_next_ch(n_cur);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept) begin
            r_rd_data  <= r_mem[mem_raddr];
            r_fwd_data <= mem_wdata;
            r_s1_act   <= t_action'(i_s_tuser);
            r_s1_sel   <= i_s_tdata[2:0];
            r_s1_pulse <= i_s_tdata[18:3];
        end
        if (s1_fire) begin
            r_out_data <= {5'd0, 3'(n_cur), n_drive};
            r_out_user <= s1_start && (r_s1_act == ACT_TICK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_min     <= MIN_RESET;
            r_max     <= MAX_RESET;
            r_cur     <= '0;
            r_rem     <= '0;
            r_drive   <= '0;
            r_s1_vld  <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_fwd     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_MIN: r_min <= i_cfg_data;
                    CFG_MAX: r_max <= i_cfg_data;
                    default: ;
                endcase
            end
            if (mem_we) begin
                r_vld[mem_waddr] <= 1'b1;
            end
            r_cur   <= n_cur;
            r_rem   <= n_rem;
            r_drive <= n_drive;
            if (s_accept) begin
                r_s1_vld <= 1'b1;
                r_rd_vld <= r_vld[mem_raddr];
                r_fwd    <= mem_we && (mem_waddr == mem_raddr);
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

endmodule

`default_nettype wire

FILE: tb/servo_pulse_sequencer_test.sv
`timescale 1ns / 1ps

module servo_pulse_sequencer_test
    import sps_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no handshake on any channel
    localparam int SETTLE_CYCLES  = 4;     // pipeline depth is two, plus margin
    localparam int HOLD_CYCLES    = 60;    // long sink hold, fills the pipeline

    // one expected result on the master side
    typedef struct packed {
        logic [7:0]      lines;
        logic [CH_W-1:0] channel;
        logic            started;
    } t_slot_report;

    // Tracks widths, slot position and limits; queues one report per request.
    class pulse_scoreboard;
        logic [15:0]     width_mem [CHANNELS];
        logic [CH_W-1:0] slot_ch;
        logic [15:0]     us_left;
        logic [7:0]      lines;
        logic [15:0]     lo_limit;
        logic [15:0]     hi_limit;
        t_slot_report    due [$];
        int unsigned     errors;

        function new();
            for (int i = 0; i < CHANNELS; i++) width_mem[i] = WIDTH_RESET;
            slot_ch  = '0;
            us_left  = '0;
            lines    = '0;
            lo_limit = MIN_RESET;
            hi_limit = MAX_RESET;
            errors   = 0;
        endfunction

        function void set_limit(t_cfg_reg idx, logic [15:0] val);
            if (idx == CFG_MIN) lo_limit = val;
            else hi_limit = val;
        endfunction

        function void note_request(t_action act, logic [CH_W-1:0] sel, logic [15:0] pulse);
            t_slot_report rep;
            logic [15:0]  w;
            rep.started = 1'b0;
            if (act == ACT_STORE) begin
                width_mem[sel] = pulse;
            end else if (us_left == 16'd0) begin
                // new slot: advance first, then clamp max then min (min wins)
                if (int'(slot_ch) == CHANNELS - 1) slot_ch = '0;
                else slot_ch = slot_ch + 1'b1;
                lines = 8'd1 << slot_ch;
                w = width_mem[slot_ch];
                if (w > hi_limit) w = hi_limit;
                if (w < lo_limit) w = lo_limit;
                width_mem[slot_ch] = w;
                us_left = (w > 16'd0) ? w - 16'd1 : 16'd0;
                rep.started = 1'b1;
            end else begin
                us_left = us_left - 16'd1;
            end
            rep.lines   = lines;
            rep.channel = slot_ch;
            due.push_back(rep);
        endfunction

        function void check_result(logic [7:0] pat, logic [CH_W-1:0] ch, logic start);
            t_slot_report want;
            if (due.size() == 0) begin
                $display("%0t unexpected result: lines %h channel %0d start %b",
                         $time, pat, ch, start);
                errors++;
                return;
            end
            want = due.pop_front();
            if (pat !== want.lines) begin
                $display("%0t mismatch line_pattern: expected %h, actual %h",
                         $time, want.lines, pat);
                errors++;
            end
            if (ch !== want.channel) begin
                $display("%0t mismatch active_channel: expected %0d, actual %0d",
                         $time, want.channel, ch);
                errors++;
            end
            if (start !== want.started) begin
                $display("%0t mismatch slot_start: expected %b, actual %b",
                         $time, want.started, start);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [23:0] i_s_tdata;    // channel_sel[2:0], raw_width[18:3], zero pad
    logic        i_s_tuser;    // action
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;    // line_pattern[7:0], active_channel[10:8], zero pad
    logic        o_m_tuser;    // slot_start
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;

    pulse_scoreboard board = new();

    bit          calm_src;      // source sends back to back while set
    bit          calm_sink;     // sink does not stall while set, except for the two long holds
    int unsigned results_seen;
    int unsigned idle_cycles;

    servo_pulse_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Called at a falling edge; returns at the falling edge after acceptance
    // with tvalid still high so a back-to-back request needs no second write.
    task automatic send_request(t_action act, logic [CH_W-1:0] sel, logic [15:0] pulse);
        int unsigned gap;
        if ($urandom_range(0, 63) == 0) calm_src = !calm_src;
        gap = calm_src ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, pulse, sel};
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_request(act, sel, pulse);
        @(negedge i_clk);
    endtask

    // Mostly ticks; stores mostly carry short widths so slots turn over
    // quickly, with occasional full-range and boundary widths.
    task automatic send_random(int unsigned count);
        t_action         act;
        logic [CH_W-1:0] sel;
        logic [15:0]     pulse;
        int unsigned     pick;
        repeat (count) begin
            act   = ($urandom_range(0, 3) == 0) ? ACT_STORE : ACT_TICK;
            sel   = CH_W'($urandom_range(0, CHANNELS - 1));
            pick  = $urandom_range(0, 19);
            if (pick < 16) pulse = 16'($urandom_range(0, 12));
            else if (pick < 18) pulse = 16'($urandom);
            else pulse = (pick == 18) ? 16'h0000 : 16'hFFFF;
            send_request(act, sel, pulse);
        end
    endtask

    // Config write; same falling-edge convention as send_request.
    task automatic write_limit(t_cfg_reg idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_limit(idx, val);
        @(negedge i_clk);
    endtask

    // Stop the source and let every outstanding result drain.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_phase(logic [15:0] lo, logic [15:0] hi, int unsigned count);
        settle();
        write_limit(CFG_MIN, lo);
        write_limit(CFG_MAX, hi);
        i_cfg_valid <= 1'b0;
        send_random(count);
    endtask

    // Sink: random stalls per result, plus two long holds while the
    // source keeps pushing, so input ready has to drop.
    initial begin
        int unsigned pause;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 63) == 0) calm_sink = !calm_sink;
            pause = calm_sink ? 0 : $urandom_range(0, 7);
            if (results_seen == 300 || results_seen == 1300) pause = HOLD_CYCLES;
            if (pause > 0) begin
                i_m_tready <= 1'b0;
                repeat (pause) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            board.check_result(o_m_tdata[7:0], o_m_tdata[8 +: CH_W], o_m_tuser);
            results_seen++;
            @(negedge i_clk);
        end
    end

    // Watchdog: any handshake on any channel resets the count.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tuser    = ACT_TICK;
        i_m_tready   = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_MIN;
        i_cfg_data   = '0;
        calm_src     = 1'b0;
        calm_sink    = 1'b0;
        results_seen = 0;
        idle_cycles  = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed, reset limits (500..2500). Width extremes, first slot on
        // channel 1 clamped up to min, an over-max width and an exact-max one.
        send_request(ACT_STORE, 3'd0, 16'h0000);
        send_request(ACT_STORE, 3'd7, 16'hFFFF);
        send_request(ACT_STORE, 3'd1, 16'h0003);
        send_request(ACT_TICK,  3'd5, 16'hFFFF);
        send_request(ACT_TICK,  3'd0, 16'h0000);
        send_request(ACT_STORE, 3'd2, 16'hFFFF);
        send_request(ACT_STORE, 3'd3, 16'h5555);
        send_request(ACT_STORE, 3'd4, 16'hAAAA);
        send_request(ACT_STORE, 3'd5, 16'h0001);
        send_request(ACT_STORE, 3'd6, 16'd2500);
        send_request(ACT_STORE, 3'd1, 16'd2501);
        repeat (6) send_request(ACT_TICK, 3'd7, 16'h0000);

        // Limit sweeps. The first ones also drain the 500-tick slot above.
        run_phase(16'd1, 16'd4, 500);        // short slots
        run_phase(16'd6, 16'd3, 300);        // min above max: min wins
        run_phase(16'd1, 16'd1, 150);        // once the leftover slot drains, every tick starts a slot
        run_phase(16'd2, 16'd9, 300);
        run_phase(16'd1, 16'hFFFF, 450);     // window 1..FFFF, nonzero raw widths pass
        run_phase(16'hFFFF, 16'hFFFF, 30);   // longest slot, left last

        settle();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/sps_pkg.sv
hdl/servo_pulse_sequencer.sv
tb/servo_pulse_sequencer_test.sv
